// ----- rtl/slst_pkg.sv -----
// ----------------------------------------------------------------------------
// slst_pkg
// Shared types and codes for the sortable LIFO stack.
// ----------------------------------------------------------------------------
package slst_pkg;

  localparam int unsigned VALUE_W = 32;
  localparam int unsigned COUNT_W = 8;

  localparam logic [1:0] ACT_PUSH = 2'd0;
  localparam logic [1:0] ACT_POP  = 2'd1;
  localparam logic [1:0] ACT_SORT = 2'd2;

  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_FULL  = 2'd1;
  localparam logic [1:0] STAT_EMPTY = 2'd2;

  localparam logic signed [VALUE_W-1:0] EMPTY_TOP = -32'sd1;

  typedef struct packed {
    logic [1:0]                action;
    logic signed [VALUE_W-1:0] value;
  } item_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] top_value;
    logic                      is_empty;
    logic [COUNT_W-1:0]        held_count;
    logic [1:0]                status;
  } result_t;

  // Per-cycle command broadcast to every cell
  typedef struct packed {
    logic push;
    logic pop;
    logic sort;
    logic phase;
  } cell_ctrl_t;

endpackage

// ----- rtl/slst_cell.sv -----
// ----------------------------------------------------------------------------
// slst_cell
// One stack slot: shifts toward the bottom on push, toward the top on pop,
// and takes part in an odd-even transposition sort with its neighbors.
// ----------------------------------------------------------------------------
module slst_cell #(
  parameter int unsigned IDX   = 0,
  parameter int unsigned DEPTH = 128
) (
  input  logic                                   clk,
  input  slst_pkg::cell_ctrl_t                   ctrl,
  input  logic [$clog2(DEPTH+1)-1:0]             fill,
  input  logic signed [slst_pkg::VALUE_W-1:0]    up,
  input  logic signed [slst_pkg::VALUE_W-1:0]    dn,
  output logic signed [slst_pkg::VALUE_W-1:0]    val
);
  import slst_pkg::*;

  localparam int unsigned FW       = $clog2(DEPTH+1);
  localparam logic        LO_PAR   = ((IDX % 2) == 1);
  localparam logic        HI_PAR   = (((IDX + 1) % 2) == 1);
  localparam logic [FW:0] IDX_P1   = (FW+1)'(IDX + 1);
  localparam logic [FW:0] IDX_SELF = (FW+1)'(IDX);

  logic act_lo;
  logic act_hi;

  // Pair (IDX, IDX+1): this cell is the upper one, keeps the larger value.
  assign act_lo = (ctrl.phase == LO_PAR) && (IDX_P1 < {1'b0, fill});
  // Pair (IDX-1, IDX): this cell is the lower one, keeps the smaller value.
  assign act_hi = (IDX > 0) && (ctrl.phase == HI_PAR) && (IDX_SELF < {1'b0, fill});

  always_ff @(posedge clk) begin
    if (ctrl.push) begin
      val <= up;
    end else if (ctrl.pop) begin
      val <= dn;
    end else if (ctrl.sort) begin
      if (act_lo && (val < dn)) begin
        val <= dn;
      end else if (act_hi && (up < val)) begin
        val <= up;
      end
    end
  end

endmodule

// ----- rtl/sortable_lifo_stack.sv -----
// ----------------------------------------------------------------------------
// sortable_lifo_stack
// Bounded LIFO of signed 32-bit values with push, pop and in-place sort.
// ----------------------------------------------------------------------------
// Input channel item_valid/item_ready carries one item beat: action and value.
// Output channel result_valid/result_ready carries one result beat per item:
// top value (-1 when empty), empty flag, count held and status.
// The stack is a row of DEPTH cells; cell 0 is the top. Push shifts every
// cell one place down, pop one place up, so both finish in the accept cycle
// and the result beat is presented in the cycle after the accept.
// Push and pop run at one item per cycle while the result beat is taken.
// Sort runs an odd-even transposition pass across the cells, one pass per
// cycle, DEPTH passes in all; the input is held off until the sort is done.
// If the receiver stalls, the result register holds its beat and the input
// is taken only once the register is free or being emptied in that cycle.
// Reset empties the stack (count zero) and clears the result valid flag;
// cell contents are not cleared.
// ----------------------------------------------------------------------------
module sortable_lifo_stack #(
  parameter int unsigned DEPTH = 128
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_ready,
  input  slst_pkg::item_t   item,
  output logic              result_valid,
  input  logic              result_ready,
  output slst_pkg::result_t result
);
  import slst_pkg::*;

  localparam int unsigned FW = $clog2(DEPTH+1);
  localparam logic [FW-1:0] FULL = FW'(DEPTH);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_SORT = 2'b10
  } state_t;

  state_t                    state;
  state_t                    state_next;
  logic [FW-1:0]             fill;
  logic [FW-1:0]             fill_next;
  logic [FW-1:0]             sort_cnt;
  logic                      sort_done;
  logic                      out_free;
  logic                      accept;
  logic                      finish;
  logic                      do_push;
  logic                      do_pop;
  logic [1:0]                stat_next;
  logic signed [VALUE_W-1:0] top_next;
  cell_ctrl_t                ctrl;
  logic signed [VALUE_W-1:0] vals [DEPTH];

  assign out_free   = !result_valid || result_ready;
  assign item_ready = (state == ST_IDLE) && out_free;
  assign accept     = item_valid && item_ready;
  assign sort_done  = (sort_cnt == FULL);
  assign finish     = (state == ST_SORT) && sort_done && out_free;

  assign do_push = accept && (item.action == ACT_PUSH) && (fill != FULL);
  assign do_pop  = accept && (item.action == ACT_POP) && (fill != '0);

  assign ctrl.push  = do_push;
  assign ctrl.pop   = do_pop;
  assign ctrl.sort  = (state == ST_SORT) && !sort_done;
  assign ctrl.phase = sort_cnt[0];

  always_comb begin
    fill_next = fill;
    if (do_push) begin
      fill_next = fill + FW'(1);
    end else if (do_pop) begin
      fill_next = fill - FW'(1);
    end
  end

  always_comb begin
    stat_next = STAT_OK;
    if (accept && (item.action == ACT_PUSH) && (fill == FULL)) begin
      stat_next = STAT_FULL;
    end else if (accept && (item.action == ACT_POP) && (fill == '0)) begin
      stat_next = STAT_EMPTY;
    end
  end

  always_comb begin
    if (do_push) begin
      top_next = item.value;
    end else if (do_pop) begin
      top_next = (fill > FW'(1)) ? vals[1] : EMPTY_TOP;
    end else begin
      top_next = (fill == '0) ? EMPTY_TOP : vals[0];
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept && (item.action == ACT_SORT)) begin
          state_next = ST_SORT;
        end
      end
      ST_SORT: begin
        if (finish) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      fill         <= '0;
      sort_cnt     <= '0;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      fill  <= fill_next;
      if (accept) begin
        sort_cnt <= '0;
      end else if (ctrl.sort) begin
        sort_cnt <= sort_cnt + FW'(1);
      end
      if ((accept && (item.action != ACT_SORT)) || finish) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  // Result payload; a sort never changes the count
  always_ff @(posedge clk) begin
    if ((accept && (item.action != ACT_SORT)) || finish) begin
      result.top_value  <= top_next;
      result.is_empty   <= (fill_next == '0);
      result.held_count <= COUNT_W'(fill_next);
      result.status     <= stat_next;
    end
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [VALUE_W-1:0] up_v;
    logic signed [VALUE_W-1:0] dn_v;
    if (i == 0) begin : g_top
      assign up_v = item.value;
    end else begin : g_mid
      assign up_v = vals[i-1];
    end
    if (i == DEPTH - 1) begin : g_bot
      assign dn_v = vals[i];
    end else begin : g_inner
      assign dn_v = vals[i+1];
    end
    slst_cell #(
      .IDX   (i),
      .DEPTH (DEPTH)
    ) u_cell (
      .clk  (clk),
      .ctrl (ctrl),
      .fill (fill),
      .up   (up_v),
      .dn   (dn_v),
      .val  (vals[i])
    );
  end

`ifndef SYNTHESIS
  a_fill_bound: assert property (@(posedge clk) disable iff (rst) fill <= FULL)
    else $error("stack count beyond depth");

  a_sort_entry: assert property (@(posedge clk) disable iff (rst)
    accept && (item.action == ACT_SORT) |=> (state == ST_SORT) && (sort_cnt == '0))
    else $error("sort did not start");

  a_sort_fill: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SORT) |=> (fill == $past(fill)))
    else $error("count changed during sort");

  a_no_push_pop_in_sort: assert property (@(posedge clk) disable iff (rst)
    ctrl.sort |-> !ctrl.push && !ctrl.pop && !item_ready)
    else $error("shift during sort");
`endif

endmodule

// ----- test/tb_sortable_lifo_stack.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_sortable_lifo_stack
// Self-checking bench for the sortable LIFO stack. A directed table covers
// the empty, full and sort corners. Random push/pop/sort traffic follows.
// Every result beat is compared against a typed row or a behavioral bench stack,
// with random idling on both channels and one long receiver hold-off.
// ----------------------------------------------------------------------------
module tb_sortable_lifo_stack;
  import slst_pkg::*;

  localparam int DEPTH        = 128;
  localparam int RAND_ITEMS   = 1600;
  localparam int PHASE_LEN    = RAND_ITEMS / 4;
  localparam int LIMIT_CYCLES = 2000000;
  localparam int HOLD_CYCLES  = 400;

  localparam logic [1:0] ACT_NOP = 2'd3;  // unused code, block answers it with the stack unchanged

  localparam logic signed [VALUE_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [VALUE_W-1:0] VAL_MIN = 32'sh8000_0000;

  typedef enum {SEG_FILL, SEG_DRAIN, SEG_MIX} seg_mode_e;

  typedef struct {
    item_t   it;
    int      reps;   // >1: row repeats with a fresh random value each time
    bit      typed;  // want holds a hand-written result
    result_t want;
  } dir_row_t;

  logic    clk          = 1'b0;
  logic    rst          = 1'b1;
  logic    item_valid   = 1'b0;
  logic    item_ready;
  item_t   item         = '0;
  logic    result_valid;
  logic    result_ready = 1'b0;
  result_t result;

  // bench copy of the stack
  logic signed [VALUE_W-1:0] model_cells [DEPTH];
  int                        model_fill = 0;

  result_t pending_results [$];
  result_t seen_want;
  int      mismatches   = 0;
  int      cycle_count  = 0;
  int      send_idle_pct = 0;
  int      recv_stall_pct = 0;
  int      hold_cycles  = 0;
  int      hold_left    = 0;

  dir_row_t dir_rows [25] = '{
    '{'{ACT_POP,  32'sd0},        1, 1'b1, '{EMPTY_TOP, 1'b1, 8'd0, STAT_EMPTY}},
    '{'{ACT_SORT, 32'sd0},        1, 1'b1, '{EMPTY_TOP, 1'b1, 8'd0, STAT_OK}},
    '{'{ACT_NOP,  32'sd0},        1, 1'b1, '{EMPTY_TOP, 1'b1, 8'd0, STAT_OK}},
    '{'{ACT_PUSH, VAL_MAX},       1, 1'b1, '{VAL_MAX,   1'b0, 8'd1, STAT_OK}},
    '{'{ACT_PUSH, VAL_MIN},       1, 1'b1, '{VAL_MIN,   1'b0, 8'd2, STAT_OK}},
    '{'{ACT_PUSH, -32'sd1},       1, 1'b1, '{-32'sd1,   1'b0, 8'd3, STAT_OK}},
    '{'{ACT_PUSH, 32'sd0},        1, 1'b1, '{32'sd0,    1'b0, 8'd4, STAT_OK}},
    '{'{ACT_NOP,  32'sh5A5A5A5A}, 1, 1'b1, '{32'sd0,    1'b0, 8'd4, STAT_OK}},
    '{'{ACT_SORT, 32'sd0},        1, 1'b1, '{VAL_MAX,   1'b0, 8'd4, STAT_OK}},
    '{'{ACT_POP,  32'sd0},        1, 1'b0, '0},
    '{'{ACT_POP,  -32'sd1},       1, 1'b0, '0},
    '{'{ACT_POP,  32'sd0},        1, 1'b0, '0},
    '{'{ACT_SORT, 32'sd0},        1, 1'b1, '{VAL_MIN,   1'b0, 8'd1, STAT_OK}},
    '{'{ACT_POP,  32'sd0},        1, 1'b1, '{EMPTY_TOP, 1'b1, 8'd0, STAT_OK}},
    '{'{ACT_PUSH, 32'sd5},        1, 1'b1, '{32'sd5,    1'b0, 8'd1, STAT_OK}},
    '{'{ACT_PUSH, 32'sd5},        1, 1'b1, '{32'sd5,    1'b0, 8'd2, STAT_OK}},
    '{'{ACT_SORT, 32'sd0},        1, 1'b1, '{32'sd5,    1'b0, 8'd2, STAT_OK}},
    '{'{ACT_PUSH, 32'sd0},      128, 1'b0, '0},
    '{'{ACT_PUSH, 32'sh12345678}, 1, 1'b0, '0},
    '{'{ACT_SORT, 32'sd0},        1, 1'b0, '0},
    '{'{ACT_POP,  32'sd0},        3, 1'b0, '0},
    '{'{ACT_PUSH, VAL_MIN},       1, 1'b0, '0},
    '{'{ACT_SORT, 32'sd0},        1, 1'b0, '0},
    '{'{ACT_POP,  32'sd0},      130, 1'b0, '0},
    '{'{ACT_POP,  32'sd0},        1, 1'b1, '{EMPTY_TOP, 1'b1, 8'd0, STAT_EMPTY}}
  };

  int idle_send_tbl [4] = '{0, 46, 0, 22};
  int idle_recv_tbl [4] = '{0, 0, 46, 22};

  sortable_lifo_stack #(.DEPTH(DEPTH)) DUT (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  always #10 clk = ~clk;

  // Applies one item to the bench stack and returns the result it must give.
  function automatic result_t stack_apply(item_t it);
    result_t            r;
    logic signed [31:0] key;
    int                 j;
    r.status = STAT_OK;
    case (it.action)
      ACT_PUSH: begin
        if (model_fill >= DEPTH) r.status = STAT_FULL;
        else begin
          model_cells[model_fill] = it.value;
          model_fill++;
        end
      end
      ACT_POP: begin
        if (model_fill == 0) r.status = STAT_EMPTY;
        else model_fill--;
      end
      ACT_SORT: begin
        // insertion sort, ascending toward the top
        for (int i = 1; i < model_fill; i++) begin
          key = model_cells[i];
          j = i;
          while (j > 0 && key < model_cells[j-1]) begin
            model_cells[j] = model_cells[j-1];
            j--;
          end
          model_cells[j] = key;
        end
      end
      default: ;
    endcase
    r.top_value  = (model_fill == 0) ? EMPTY_TOP : model_cells[model_fill-1];
    r.is_empty   = (model_fill == 0);
    r.held_count = model_fill[COUNT_W-1:0];
    return r;
  endfunction

  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(3))
      0: return 32'($urandom_range(16)) - 32'sd8;  // narrow range, many duplicates
      1: begin
        case ($urandom_range(3))
          0: return VAL_MAX;
          1: return VAL_MIN;
          2: return 32'sd0;
          default: return -32'sd1;
        endcase
      end
      default: return $urandom;
    endcase
  endfunction

  // Offers one item beat, waits for it to be taken, then queues its result.
  task automatic offer_item(item_t it, bit typed, result_t want);
    int      gap;
    result_t predicted;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct) gap++;
    if (gap != 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_valid <= 1'b1;
    item       <= it;
    @(posedge clk);
    while (!item_ready) @(posedge clk);
    predicted = stack_apply(it);
    pending_results.push_back(typed ? want : predicted);
  endtask

  // receiver: random stalls plus one long hold-off
  always @(posedge clk) begin
    if (hold_cycles != 0) begin
      hold_left   = hold_cycles;
      hold_cycles = 0;
    end
    if (hold_left != 0) begin
      hold_left--;
      result_ready <= 1'b0;
    end else begin
      result_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && result_valid && result_ready) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result beat: top %0d empty %0b count %0d status %0d",
                   result.top_value, result.is_empty, result.held_count, result.status);
      end else begin
        seen_want = pending_results.pop_front();
        if (result.top_value !== seen_want.top_value ||
            result.is_empty !== seen_want.is_empty ||
            result.held_count !== seen_want.held_count ||
            result.status !== seen_want.status) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result mismatch: top %0d/%0d empty %0b/%0b count %0d/%0d status %0d/%0d",
                     seen_want.top_value, result.top_value, seen_want.is_empty,
                     result.is_empty, seen_want.held_count, result.held_count,
                     seen_want.status, result.status);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    item_t     cur;
    seg_mode_e seg_mode;
    int        seg_left;
    int        push_w;
    int        pick;
    seg_mode = SEG_MIX;
    seg_left = 0;
    push_w   = 0;

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[r]) begin
      for (int k = 0; k < dir_rows[r].reps; k++) begin
        cur = dir_rows[r].it;
        if (dir_rows[r].reps > 1) cur.value = pick_value();
        offer_item(cur, dir_rows[r].typed, dir_rows[r].want);
      end
    end

    for (int n = 0; n < RAND_ITEMS; n++) begin
      if (n % PHASE_LEN == 0 && n / PHASE_LEN < 4) begin
        send_idle_pct  = idle_send_tbl[n / PHASE_LEN];
        recv_stall_pct = idle_recv_tbl[n / PHASE_LEN];
        // long receiver hold-off while the sender keeps offering beats
        if (n == 0) hold_cycles = HOLD_CYCLES;
      end
      if (seg_left == 0) begin
        seg_mode = seg_mode_e'($urandom_range(2));
        seg_left = $urandom_range(20, 200);
        case (seg_mode)
          SEG_FILL:  push_w = 80;
          SEG_DRAIN: push_w = 12;
          default:   push_w = 47;
        endcase
      end
      seg_left--;
      pick = $urandom_range(99);
      cur.value = pick_value();
      if (pick < 5)               cur.action = ACT_SORT;
      else if (pick < 8)          cur.action = ACT_NOP;
      else if (pick < 8 + push_w) cur.action = ACT_PUSH;
      else                        cur.action = ACT_POP;
      offer_item(cur, 1'b0, '0);
    end

    item_valid <= 1'b0;
    recv_stall_pct = 0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DEPTH + 20) @(posedge clk);

    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
